// ===== design/utf8cd_pkg.sv =====
// Shared types and constants for the UTF-8 Cyrillic detector.
package utf8cd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned RSP_W   = 16;

   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd4;

   localparam logic [CP_W-1:0] CP_MIN_2BYTE  = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_3BYTE  = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_4BYTE  = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO       = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI       = 21'h00DFFF;
   localparam logic [CP_W-1:0] CYR_BASE_LO   = 21'h000400;
   localparam logic [CP_W-1:0] CYR_BASE_HI   = 21'h00052F;
   localparam logic [CP_W-1:0] CYR_EXTC_LO   = 21'h001C80;
   localparam logic [CP_W-1:0] CYR_EXTC_HI   = 21'h001C8F;
   localparam logic [CP_W-1:0] CYR_EXTA_LO   = 21'h002DE0;
   localparam logic [CP_W-1:0] CYR_EXTA_HI   = 21'h002DFF;
   localparam logic [CP_W-1:0] CYR_EXTB_LO   = 21'h00A640;
   localparam logic [CP_W-1:0] CYR_EXTB_HI   = 21'h00A69F;
   localparam logic [CP_W-1:0] CYR_EXTD_LO   = 21'h01E030;
   localparam logic [CP_W-1:0] CYR_EXTD_HI   = 21'h01E08F;

   typedef enum logic [1:0] {
      DEC_NONE = 2'd0,
      DEC_CYR  = 2'd1,
      DEC_BAD  = 2'd2
   } decision_type;

   typedef struct packed {
      logic [1:0]         bytes_remaining;
      logic [1:0]         sequence_length;
      logic [CP_W-1:0]    partial_code_point;
      logic [COUNT_W-1:0] cyrillic_tally;
      decision_type       decision;
   } msg_state_type;

   typedef struct packed {
      logic               is_cyrillic_message;
      logic               invalid_utf8;
      logic [COUNT_W-1:0] cyrillic_count;
   } result_type;

   localparam msg_state_type MSG_CLEAR = '{
      bytes_remaining:    2'd0,
      sequence_length:    2'd0,
      partial_code_point: '0,
      cyrillic_tally:     '0,
      decision:           DEC_NONE
   };

endpackage

// ===== design/utf8cd_step.sv =====
// Per-word decode step: next message state and the verdict on a terminating zero.
module utf8cd_step (
   input  utf8cd_pkg::msg_state_type        cur,
   input  logic [utf8cd_pkg::BYTE_W-1:0]    byte_value,
   input  logic [utf8cd_pkg::COUNT_W-1:0]   threshold,
   output utf8cd_pkg::msg_state_type        nxt,
   output logic                             emit,
   output utf8cd_pkg::result_type           result
);
   import utf8cd_pkg::*;

   logic [CP_W-1:0]    shifted_cp;
   logic [CP_W-1:0]    cp;
   logic               cp_valid;
   logic               cp_ok;
   logic               cyr_hit;
   logic [COUNT_W:0]   tally_inc;
   msg_state_type      mid;

   assign shifted_cp = {cur.partial_code_point[CP_W-7:0], byte_value[5:0]};

   // overlong, surrogate and range checks on the completed sequence
   always_comb begin
      case (cur.sequence_length)
         2'd1:    cp_ok = (shifted_cp >= CP_MIN_2BYTE);
         2'd2:    cp_ok = (shifted_cp >= CP_MIN_3BYTE) &&
                          !((shifted_cp >= SURR_LO) && (shifted_cp <= SURR_HI));
         2'd3:    cp_ok = (shifted_cp >= CP_MIN_4BYTE) && (shifted_cp <= CP_MAX);
         default: cp_ok = 1'b0;
      endcase
   end

   always_comb begin
      mid      = cur;
      emit     = 1'b0;
      cp       = shifted_cp;
      cp_valid = 1'b0;
      case (cur.decision)
         DEC_NONE: begin
            if (cur.bytes_remaining == 2'd0) begin
               if (byte_value == '0) begin
                  emit = 1'b1;
               end else if (!byte_value[7]) begin
                  cp       = {{(CP_W-BYTE_W){1'b0}}, byte_value};
                  cp_valid = 1'b1;
               end else if (byte_value[7:5] == 3'b110) begin
                  mid.bytes_remaining    = 2'd1;
                  mid.sequence_length    = 2'd1;
                  mid.partial_code_point = {{(CP_W-5){1'b0}}, byte_value[4:0]};
               end else if (byte_value[7:4] == 4'b1110) begin
                  mid.bytes_remaining    = 2'd2;
                  mid.sequence_length    = 2'd2;
                  mid.partial_code_point = {{(CP_W-4){1'b0}}, byte_value[3:0]};
               end else if (byte_value[7:3] == 5'b11110) begin
                  mid.bytes_remaining    = 2'd3;
                  mid.sequence_length    = 2'd3;
                  mid.partial_code_point = {{(CP_W-3){1'b0}}, byte_value[2:0]};
               end else begin
                  mid.decision           = DEC_BAD;
                  mid.bytes_remaining    = 2'd0;
                  mid.sequence_length    = 2'd0;
                  mid.partial_code_point = '0;
               end
            end else begin
               if ((byte_value == '0) || (byte_value[7:6] != 2'b10)) begin
                  // zero inside a sequence also ends the message
                  emit                   = (byte_value == '0);
                  mid.decision           = DEC_BAD;
                  mid.bytes_remaining    = 2'd0;
                  mid.sequence_length    = 2'd0;
                  mid.partial_code_point = '0;
               end else begin
                  mid.partial_code_point = shifted_cp;
                  mid.bytes_remaining    = cur.bytes_remaining - 2'd1;
                  if (cur.bytes_remaining == 2'd1) begin
                     mid.sequence_length    = 2'd0;
                     mid.partial_code_point = '0;
                     if (cp_ok) begin
                        cp_valid = 1'b1;
                     end else begin
                        mid.decision = DEC_BAD;
                     end
                  end
               end
            end
         end
         default: begin
            emit = (byte_value == '0);
         end
      endcase
   end

   assign cyr_hit = cp_valid && (
      ((cp >= CYR_BASE_LO) && (cp <= CYR_BASE_HI)) ||
      ((cp >= CYR_EXTC_LO) && (cp <= CYR_EXTC_HI)) ||
      ((cp >= CYR_EXTA_LO) && (cp <= CYR_EXTA_HI)) ||
      ((cp >= CYR_EXTB_LO) && (cp <= CYR_EXTB_HI)) ||
      ((cp >= CYR_EXTD_LO) && (cp <= CYR_EXTD_HI)));

   assign tally_inc = {1'b0, cur.cyrillic_tally} + {{COUNT_W{1'b0}}, 1'b1};

   always_comb begin
      msg_state_type counted;
      counted = mid;
      if (cyr_hit) begin
         // compare the unsaturated count, report the saturated one
         if (tally_inc > {1'b0, threshold}) begin
            counted.decision = DEC_CYR;
         end
         counted.cyrillic_tally = tally_inc[COUNT_W] ? {COUNT_W{1'b1}}
                                                     : tally_inc[COUNT_W-1:0];
      end
      result.is_cyrillic_message = (counted.decision == DEC_CYR);
      result.invalid_utf8        = (counted.decision != DEC_NONE) &&
                                   (counted.decision != DEC_CYR);
      result.cyrillic_count      = counted.cyrillic_tally;
      nxt = emit ? MSG_CLEAR : counted;
   end

endmodule

// ===== design/utf8_cyrillic_detector.sv =====
// Top level of the streaming UTF-8 decoder with Cyrillic message detection.
// A verdict word is registered: it appears on rsp_ the cycle after its terminating zero is taken.
// Throughput: one byte per cycle while not stalled; message state updates on every accepted word.
// The result register holds one verdict; req_ stalls only while it is full and rsp_tready is low.
// Reset (synchronous, active high): clears message state, drops any pending verdict,
// and loads the threshold with 4.
module utf8_cyrillic_detector (
   input  logic        clock,
   input  logic        reset,
   // request stream: tdata[7:0] = byte_value
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // response stream: tdata[0] = is_cyrillic_message, [1] = invalid_utf8,
   // [9:2] = cyrillic_count, [15:10] = zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   // threshold write channel: data[7:0] = count_threshold
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);
   import utf8cd_pkg::*;

   msg_state_type        state_ff, state_in;
   logic [COUNT_W-1:0]   threshold_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_result_ff;
   logic                 req_accept;
   logic                 step_emit;
   result_type           step_result;

   // Always take threshold writes; the user must send only while the block is idle, unenforced.
   assign csr_ready = 1'b1;

   // Take a new word whenever the result slot is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   utf8cd_step u_step (
      .cur        (state_ff),
      .byte_value (req_tdata),
      .threshold  (threshold_ff),
      .nxt        (state_in),
      .emit       (step_emit),
      .result     (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   // Advance message state only on accepted words.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MSG_CLEAR;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Hold a verdict until the downstream takes it; load a new one on a terminating zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept && step_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && step_emit) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-COUNT_W-2){1'b0}},
                        rsp_result_ff.cyrillic_count,
                        rsp_result_ff.invalid_utf8,
                        rsp_result_ff.is_cyrillic_message};

endmodule

// ===== tb/utf8cd_verdict_checker.sv =====
// Scoreboard for the UTF-8 Cyrillic detector: predicts each verdict word and checks it.
module utf8cd_verdict_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_data,
   output int unsigned failures,
   output int unsigned verdicts_waiting
);
   import utf8cd_pkg::*;

   // Predicted decoder state, kept at the block's widths.
   logic [1:0]         cont_left;
   logic [1:0]         cont_total;
   logic [CP_W-1:0]    cp_acc;
   logic [COUNT_W-1:0] cyr_tally;
   logic [COUNT_W-1:0] threshold;
   decision_type       verdict;

   result_type         verdicts_due[$];
   int unsigned        verdict_index;

   initial begin
      failures         = 0;
      verdicts_waiting = 0;
      verdict_index    = 0;
   end

   function automatic logic is_cyrillic(input logic [CP_W-1:0] cp);
      return (cp >= CYR_BASE_LO && cp <= CYR_BASE_HI) ||
             (cp >= CYR_EXTC_LO && cp <= CYR_EXTC_HI) ||
             (cp >= CYR_EXTA_LO && cp <= CYR_EXTA_HI) ||
             (cp >= CYR_EXTB_LO && cp <= CYR_EXTB_HI) ||
             (cp >= CYR_EXTD_LO && cp <= CYR_EXTD_HI);
   endfunction

   function automatic logic code_point_legal(input logic [CP_W-1:0] cp, input logic [1:0] conts);
      case (conts)
         2'd1:    return cp >= CP_MIN_2BYTE;
         2'd2:    return cp >= CP_MIN_3BYTE && !(cp >= SURR_LO && cp <= SURR_HI);
         default: return cp >= CP_MIN_4BYTE && cp <= CP_MAX;
      endcase
   endfunction

   task automatic clear_message();
      cont_left  = 2'd0;
      cont_total = 2'd0;
      cp_acc     = '0;
      cyr_tally  = '0;
      verdict    = DEC_NONE;
   endtask

   task automatic flag_invalid();
      verdict    = DEC_BAD;
      cont_left  = 2'd0;
      cont_total = 2'd0;
      cp_acc     = '0;
   endtask

   // The comparison sees the unsaturated count, so threshold 255 still trips.
   task automatic count_code_point(input logic [CP_W-1:0] cp);
      logic [COUNT_W:0] next_tally;
      if (is_cyrillic(cp)) begin
         next_tally = {1'b0, cyr_tally} + 1'b1;
         if (next_tally > {1'b0, threshold})
            verdict = DEC_CYR;
         cyr_tally = next_tally[COUNT_W] ? '1 : next_tally[COUNT_W-1:0];
      end
   endtask

   task automatic post_verdict();
      result_type r;
      r.is_cyrillic_message = (verdict == DEC_CYR);
      r.invalid_utf8        = (verdict >= DEC_BAD);
      r.cyrillic_count      = cyr_tally;
      verdicts_due.push_back(r);
      clear_message();
   endtask

   task automatic decode_byte(input logic [7:0] b);
      logic [CP_W-1:0] cp;
      logic [1:0]      conts;
      if (verdict != DEC_NONE) begin
         if (b == 8'h00)
            post_verdict();
      end else if (cont_left == 2'd0) begin
         if (b == 8'h00)
            post_verdict();
         else if (b[7] == 1'b0)
            count_code_point({13'd0, b});
         else if (b[7:5] == 3'b110) begin
            cont_left  = 2'd1;
            cont_total = 2'd1;
            cp_acc     = {16'd0, b[4:0]};
         end else if (b[7:4] == 4'b1110) begin
            cont_left  = 2'd2;
            cont_total = 2'd2;
            cp_acc     = {17'd0, b[3:0]};
         end else if (b[7:3] == 5'b11110) begin
            cont_left  = 2'd3;
            cont_total = 2'd3;
            cp_acc     = {18'd0, b[2:0]};
         end else
            flag_invalid();
      end else if (b == 8'h00) begin
         flag_invalid();
         post_verdict();
      end else if (b[7:6] != 2'b10) begin
         flag_invalid();
      end else begin
         cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
         cont_left = cont_left - 2'd1;
         if (cont_left == 2'd0) begin
            cp         = cp_acc;
            conts      = cont_total;
            cont_total = 2'd0;
            cp_acc     = '0;
            if (conts == 2'd0 || !code_point_legal(cp, conts))
               flag_invalid();
            else
               count_code_point(cp);
         end
      end
   endtask

   task automatic report(input string msg);
      $display("[%0t] verdict %0d: %s", $realtime, verdict_index, msg);
      failures++;
   endtask

   task automatic check_verdict(input logic [15:0] word);
      result_type want;
      if (verdicts_due.size() == 0) begin
         report($sformatf("unexpected verdict word %h", word));
      end else begin
         want = verdicts_due.pop_front();
         if (word[0] !== want.is_cyrillic_message)
            report($sformatf("is_cyrillic_message %b, expected %b",
                             word[0], want.is_cyrillic_message));
         if (word[1] !== want.invalid_utf8)
            report($sformatf("invalid_utf8 %b, expected %b", word[1], want.invalid_utf8));
         if (word[9:2] !== want.cyrillic_count)
            report($sformatf("cyrillic_count %0d, expected %0d",
                             word[9:2], want.cyrillic_count));
      end
      verdict_index++;
   endtask

   // Take the result side first: a word leaving now belongs to an earlier byte.
   always @(posedge clock) begin
      if (reset) begin
         clear_message();
         threshold = THRESHOLD_RESET;
         verdicts_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_verdict(rsp_tdata);
         if (csr_valid && csr_ready)
            threshold = csr_data;
         if (req_tvalid && req_tready)
            decode_byte(req_tdata);
      end
      verdicts_waiting <= verdicts_due.size();
   end

endmodule

// ===== tb/utf8_cyrillic_detector_test.sv =====
// Top of the UTF-8 Cyrillic detector testbench: stimulus, idling and the final verdict.
module utf8_cyrillic_detector_test;
   import utf8cd_pkg::*;

   localparam logic [7:0]  BYTE_END      = 8'h00;
   localparam int unsigned IDLE_LIMIT    = 5000;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam int unsigned OPENING_LEN   = 42;
   localparam int unsigned EDGE_COUNT    = 26;

   // Opening messages, each closed by a zero byte:
   // empty message, top ASCII, overlong two-byte form, surrogate,
   // value above the Unicode ceiling, stray continuation as lead, 0xFF as lead,
   // zero inside a sequence, broken continuation, and six Cyrillic characters
   // from five ranges that cross the reset threshold.
   localparam logic [7:0] OPENING_BYTES [OPENING_LEN] = '{
      8'h00,
      8'h7F, 8'h00,
      8'hC0, 8'hAF, 8'h00,
      8'hED, 8'hA0, 8'h80, 8'h00,
      8'hF4, 8'h90, 8'h80, 8'h80, 8'h00,
      8'h80, 8'h00,
      8'hFF, 8'h00,
      8'hE2, 8'h00,
      8'hD0, 8'h41, 8'h00,
      8'hD0, 8'h80, 8'hD4, 8'hAF, 8'hE1, 8'hB2, 8'h80, 8'hE2, 8'hB7, 8'hBF,
      8'hF0, 8'h9E, 8'h80, 8'hB0, 8'hEA, 8'h9A, 8'h9F, 8'h00
   };

   // Code points around the Cyrillic edges, 3/4-byte minimums and surrogates.
   localparam logic [CP_W-1:0] CP_EDGES [EDGE_COUNT] = '{
      CYR_BASE_LO - 1'b1, CYR_BASE_LO, CYR_BASE_HI, CYR_BASE_HI + 1'b1,
      CYR_EXTC_LO - 1'b1, CYR_EXTC_LO, CYR_EXTC_HI, CYR_EXTC_HI + 1'b1,
      CYR_EXTA_LO - 1'b1, CYR_EXTA_LO, CYR_EXTA_HI, CYR_EXTA_HI + 1'b1,
      CYR_EXTB_LO - 1'b1, CYR_EXTB_LO, CYR_EXTB_HI, CYR_EXTB_HI + 1'b1,
      CYR_EXTD_LO - 1'b1, CYR_EXTD_LO, CYR_EXTD_HI, CYR_EXTD_HI + 1'b1,
      CP_MIN_3BYTE - 1'b1, CP_MIN_3BYTE, CP_MIN_4BYTE - 1'b1, CP_MIN_4BYTE,
      SURR_LO - 1'b1, SURR_HI + 1'b1
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] byte_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [0] is_cyrillic_message, [1] invalid_utf8,
                                      // [9:2] cyrillic_count, [15:10] zero
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = 8'h00;   // [7:0] count_threshold

   int unsigned failures;
   int unsigned verdicts_waiting;
   int unsigned bytes_taken = 0;
   int unsigned burst_left  = 0;
   int unsigned idle_cycles = 0;
   logic [15:0] stall_phase = '0;

   always #10 clock = ~clock;

   utf8_cyrillic_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   utf8cd_verdict_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .failures         (failures),
      .verdicts_waiting (verdicts_waiting)
   );

   // Receiver back-pressure: rotate on stall_phase[10:9] through always ready,
   // coin-flip stalls, mostly stalled, and ready while stall_phase % 5 < 3.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[10:9])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((stall_phase % 5) < 3);
      endcase
   end

   // Watchdog: any word moving on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
         $display("utf8_cyrillic_detector test failed");
         $finish;
      end
   end

   // Present one byte and hold it until taken. Bursts of random length are
   // separated by random gaps; a gap of zero makes long back-to-back runs.
   // Valid is left high on return so the next byte follows without a bubble.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_taken++;
   endtask

   // Encode cp in len bytes and send the first keep of them. A len larger
   // than the value needs gives an overlong form.
   task automatic send_encoded(input logic [CP_W-1:0] cp, input int unsigned len,
                               input int unsigned keep);
      logic [7:0] enc [4];
      case (len)
         1: enc[0] = {1'b0, cp[6:0]};
         2: begin
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
         end
         3: begin
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
         end
         default: begin
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int unsigned i = 0; i < keep; i++)
         send_byte(enc[2'(i)]);
   endtask

   task automatic send_code_point(input logic [CP_W-1:0] cp);
      int unsigned len;
      len = (cp < CP_MIN_2BYTE) ? 1 : (cp < CP_MIN_3BYTE) ? 2 : (cp < CP_MIN_4BYTE) ? 3 : 4;
      send_encoded(cp, len, len);
   endtask

   task automatic send_cyrillic_char();
      case ($urandom_range(0, 4))
         0, 1:    send_code_point(CP_W'($urandom_range(CYR_BASE_LO, CYR_BASE_HI)));
         2:       send_code_point(CP_W'($urandom_range(CYR_EXTC_LO, CYR_EXTC_HI)));
         3:       send_code_point(CP_W'($urandom_range(CYR_EXTA_LO, CYR_EXTA_HI)));
         default: send_code_point(CP_W'($urandom_range(CYR_EXTB_LO, CYR_EXTB_HI)));
      endcase
   endtask

   // One malformed character of a random kind.
   task automatic send_broken_char();
      int unsigned len;
      logic [7:0]  raw;
      len = $urandom_range(2, 4);
      case ($urandom_range(0, 5))
         0: send_encoded(CP_W'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF)),
                         len, len);
         1: send_encoded(CP_W'($urandom_range(SURR_LO, SURR_HI)), 3, 3);
         2: send_encoded(CP_W'($urandom_range(CP_MAX + 1, 21'h1FFFFF)), 4, 4);
         3: begin
            raw = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                       : 8'($urandom_range(8'hF8, 8'hFF));
            send_byte(raw);
         end
         4: begin
            // cut short by a byte that is neither zero nor a continuation
            send_encoded(CP_W'($urandom_range(0, 21'h1FFFFF)), len,
                         $urandom_range(1, len - 1));
            raw = 8'($urandom_range(1, 255));
            if (raw[7:6] == 2'b10)
               raw[6] = 1'b1;
            send_byte(raw);
         end
         default: begin
            // zero inside the sequence ends the message right there
            send_encoded(CP_W'($urandom_range(0, 21'h1FFFFF)), len,
                         $urandom_range(1, len - 1));
            send_byte(BYTE_END);
         end
      endcase
   endtask

   task automatic send_char();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)
         send_code_point(CP_W'($urandom_range(1, 8'h7F)));
      else if (pick < 50)
         send_cyrillic_char();
      else if (pick < 56)
         send_code_point(CP_W'($urandom_range(CP_MIN_2BYTE, CP_MIN_3BYTE - 1)));
      else if (pick < 62)
         send_code_point(CP_W'($urandom_range(CP_MIN_3BYTE, CP_MIN_4BYTE - 1)));
      else if (pick < 70)
         send_code_point(CP_W'($urandom_range(CYR_EXTD_LO, CYR_EXTD_HI)));
      else if (pick < 75)
         send_code_point(CP_W'($urandom_range(CP_MIN_4BYTE, CP_MAX)));
      else if (pick < 84)
         send_code_point(CP_EDGES[5'($urandom_range(0, EDGE_COUNT - 1))]);
      else
         send_broken_char();
   endtask

   // Mostly well-formed messages with random content; now and then raw noise.
   task automatic send_message();
      int unsigned n;
      logic [7:0]  raw;
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(1, 10);
         for (int unsigned i = 0; i < n; i++) begin
            raw = 8'($urandom_range(0, 255));
            send_byte(raw);
         end
      end else begin
         n = $urandom_range(0, 12);
         for (int unsigned i = 0; i < n; i++)
            send_char();
      end
      send_byte(BYTE_END);
   endtask

   task automatic run_messages(input int unsigned budget);
      int unsigned stop;
      stop = bytes_taken + budget;
      while (bytes_taken < stop)
         send_message();
   endtask

   // Two-byte characters from the base range keep a long run short.
   task automatic send_cyrillic_run(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_code_point(CP_W'($urandom_range(CYR_BASE_LO, CYR_BASE_HI)));
      send_byte(BYTE_END);
   endtask

   // Drop valid, hold until every verdict has come back, then let the
   // pipeline settle so the block is idle for a threshold write.
   task automatic finish_phase();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (verdicts_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset threshold of 4
      for (int unsigned k = 0; k < OPENING_LEN; k++)
         send_byte(OPENING_BYTES[6'(k)]);
      finish_phase();

      // threshold extremes and small values where verdicts flip often
      write_threshold(8'd0);
      run_messages(25);
      finish_phase();
      write_threshold(8'd1);
      run_messages(25);
      finish_phase();
      for (int unsigned p = 0; p < 2; p++) begin
         write_threshold(8'($urandom_range(2, 8)));
         run_messages(25);
         finish_phase();
      end
      write_threshold(8'($urandom_range(0, 255)));
      run_messages(25);
      finish_phase();

      // at 255 the tally saturates: the 256th character decides and the
      // count still reads 255
      write_threshold(8'hFF);
      send_cyrillic_run(256);
      finish_phase();

      if (failures == 0)
         $display("utf8_cyrillic_detector test passed");
      else
         $display("utf8_cyrillic_detector test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/utf8cd_pkg.sv
design/utf8cd_step.sv
design/utf8_cyrillic_detector.sv
tb/utf8cd_verdict_checker.sv
tb/utf8_cyrillic_detector_test.sv
